// File: hw/rtl/log_record_block_framer_unit_assert.svh
// ---------------------------------------------------------------------------
// Log record block framer - assertion macros
// Shared property forms for the checker. Each expects clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef LOG_RECORD_BLOCK_FRAMER_UNIT_ASSERT_SVH
`define LOG_RECORD_BLOCK_FRAMER_UNIT_ASSERT_SVH

// Same-cycle implication
`define LRBF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define LRBF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/lrbf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Log record block framer - package
// Block geometry, field widths, byte kind codes and the per-word run plan.
// ---------------------------------------------------------------------------
package lrbf_pkg;

    // Block geometry
    localparam int BLOCK_BYTES = 32768;
    localparam int HDR_BYTES   = 8;
    localparam int POS_W       = 16;

    // Field widths
    localparam int LEN_W   = 24;
    localparam int BYTE_W  = 8;
    localparam int STAMP_W = 32;
    localparam int KIND_W  = 2;
    localparam int CODE_W  = 8;
    localparam int CFG_IDX_W = 2;

    // Output byte kinds
    localparam logic [KIND_W-1:0] KIND_PAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HDR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PAY = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_FULL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_FIRST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_MIDDLE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_LAST   = 2'd3;

    // Everything one input word turns into, in output order:
    // holdover byte, tail padding, up to two headers, payload byte
    typedef struct packed {
        logic               hold_v;
        logic [BYTE_W-1:0]  hold_byte;
        logic [2:0]         pad_cnt;
        logic [1:0]         hdr_cnt;
        logic [POS_W-1:0]   frag1;
        logic [CODE_W-1:0]  code1;
        logic [POS_W-1:0]   frag2;
        logic [CODE_W-1:0]  code2;
        logic [STAMP_W-1:0] stamp;
        logic               pay_v;
        logic [BYTE_W-1:0]  pay_byte;
    } lrbf_plan_t;

endpackage

// File: hw/rtl/lrbf_plan.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Log record block framer - planner
// Holds the framing state and type registers, and works out in one pass
// what an accepted word produces: padding, headers and the payload byte.
// ---------------------------------------------------------------------------
module lrbf_plan
    import lrbf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CODE_W-1:0]    cfg_data,
    input  logic                 accept,
    input  logic [LEN_W-1:0]     record_length,
    input  logic [BYTE_W-1:0]    payload_byte,
    input  logic [STAMP_W-1:0]   timestamp_seconds,
    output lrbf_plan_t           plan
);

    localparam logic [POS_W-1:0] BLK  = POS_W'(BLOCK_BYTES);
    localparam logic [POS_W-1:0] HDR  = POS_W'(HDR_BYTES);
    localparam logic [POS_W-1:0] AVL2 = POS_W'(BLOCK_BYTES - HDR_BYTES);

    logic [CODE_W-1:0] full_code_reg, first_code_reg, middle_code_reg, last_code_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [LEN_W-1:0]  rbl_reg, rbl_next;
    logic [POS_W-1:0]  fbl_reg, fbl_next;
    logic              first_reg, first_next;
    logic              hold_v_reg, hold_v_next;
    logic [BYTE_W-1:0] hold_byte_reg;

    logic              rec_start, do_open, first_eff, is_short, two_hdr, has_pay;
    logic              done1, done2;
    logic [LEN_W-1:0]  r_eff;
    logic [POS_W-1:0]  leftover, p0, avail1, frag1, frag2, pos_hdr, fbl_hdr;
    logic [CODE_W-1:0] code1, code2;

    // Fragment opening
    always_comb
    begin
        rec_start = (rbl_reg == '0);
        r_eff     = rec_start ? record_length : rbl_reg;
        first_eff = rec_start | first_reg;
        do_open   = rec_start | (fbl_reg == '0);

        leftover = BLK - pos_reg;
        is_short = (leftover < HDR);
        p0       = is_short ? '0 : pos_reg;
        avail1   = BLK - HDR - p0;

        frag1 = (r_eff < LEN_W'(avail1)) ? r_eff[POS_W-1:0] : avail1;
        done1 = (LEN_W'(frag1) == r_eff);
        if (first_eff)
        begin
            code1 = done1 ? full_code_reg : first_code_reg;
        end
        else
        begin
            code1 = done1 ? last_code_reg : middle_code_reg;
        end

        // header-only fragment at the block tail: next one starts a new block
        frag2   = (r_eff < LEN_W'(AVL2)) ? r_eff[POS_W-1:0] : AVL2;
        done2   = (LEN_W'(frag2) == r_eff);
        code2   = done2 ? last_code_reg : middle_code_reg;
        has_pay = (r_eff != '0);
        two_hdr = do_open && has_pay && (frag1 == '0);

        if (!do_open)
        begin
            pos_hdr = pos_reg;
            fbl_hdr = fbl_reg;
        end
        else if (two_hdr)
        begin
            pos_hdr = HDR;
            fbl_hdr = frag2;
        end
        else
        begin
            pos_hdr = p0 + HDR;
            fbl_hdr = frag1;
        end
    end

    // Payload consumption and next state
    always_comb
    begin
        pos_next = has_pay ? pos_hdr + 1'b1 : pos_hdr;
        fbl_next = has_pay ? fbl_hdr - 1'b1 : fbl_hdr;
        rbl_next = has_pay ? r_eff - 1'b1 : r_eff;
        if (rbl_next == '0)
        begin
            first_next = 1'b1;
        end
        else
        begin
            first_next = do_open ? 1'b0 : first_reg;
        end
        hold_v_next = two_hdr;
    end

    // Run plan for the emitter
    always_comb
    begin
        plan.hold_v    = hold_v_reg;
        plan.hold_byte = hold_byte_reg;
        plan.pad_cnt   = (do_open && is_short) ? leftover[2:0] : 3'd0;
        plan.hdr_cnt   = !do_open ? 2'd0 : (two_hdr ? 2'd2 : 2'd1);
        plan.frag1     = frag1;
        plan.code1     = code1;
        plan.frag2     = frag2;
        plan.code2     = code2;
        plan.stamp     = timestamp_seconds;
        plan.pay_v     = has_pay && !two_hdr;
        plan.pay_byte  = payload_byte;
    end

    // Type code registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_code_reg   <= 8'd1;
            first_code_reg  <= 8'd2;
            middle_code_reg <= 8'd3;
            last_code_reg   <= 8'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TYPE_FULL:   full_code_reg   <= cfg_data;
                CFG_TYPE_FIRST:  first_code_reg  <= cfg_data;
                CFG_TYPE_MIDDLE: middle_code_reg <= cfg_data;
                CFG_TYPE_LAST:   last_code_reg   <= cfg_data;
                default:         full_code_reg   <= full_code_reg;
            endcase
        end
    end

    // Framing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            rbl_reg    <= '0;
            fbl_reg    <= '0;
            first_reg  <= 1'b1;
            hold_v_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            rbl_reg    <= rbl_next;
            fbl_reg    <= fbl_next;
            first_reg  <= first_next;
            hold_v_reg <= hold_v_next;
        end
    end

    // Held payload byte
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_byte_reg <= payload_byte;
        end
    end

endmodule

// File: hw/rtl/lrbf_emit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Log record block framer - emitter
// Holds the current run plan and walks it into the output register one byte
// per cycle while the output is not stalled. Takes the next plan as the last byte leaves.
// ---------------------------------------------------------------------------
module lrbf_emit
    import lrbf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  lrbf_plan_t        plan_in,
    output logic              ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic [KIND_W-1:0] byte_kind,
    output logic              last_of_run
);

    localparam logic [2:0] PH_HOLD = 3'd0;
    localparam logic [2:0] PH_PAD  = 3'd1;
    localparam logic [2:0] PH_HDR1 = 3'd2;
    localparam logic [2:0] PH_HDR2 = 3'd3;
    localparam logic [2:0] PH_PAY  = 3'd4;
    localparam logic [2:0] PH_DONE = 3'd5;

    // First non-empty phase after the given one
    function automatic logic [2:0] next_phase(input lrbf_plan_t p, input logic [2:0] cur);
        logic [2:0] nxt;
        begin
            nxt = PH_DONE;
            unique case (cur)
                PH_HOLD:
                begin
                    if (p.pad_cnt != 3'd0)     nxt = PH_PAD;
                    else if (p.hdr_cnt != 2'd0) nxt = PH_HDR1;
                    else if (p.pay_v)          nxt = PH_PAY;
                end
                PH_PAD:
                begin
                    if (p.hdr_cnt != 2'd0) nxt = PH_HDR1;
                    else if (p.pay_v)     nxt = PH_PAY;
                end
                PH_HDR1:
                begin
                    if (p.hdr_cnt == 2'd2) nxt = PH_HDR2;
                    else if (p.pay_v)     nxt = PH_PAY;
                end
                PH_HDR2:
                begin
                    if (p.pay_v) nxt = PH_PAY;
                end
                default:
                begin
                    nxt = PH_DONE;
                end
            endcase
            return nxt;
        end
    endfunction

    // Header byte: 24-bit length LE, 32-bit stamp LE, type
    function automatic logic [BYTE_W-1:0] hdr_byte(input logic [POS_W-1:0] frag,
                                                   input logic [STAMP_W-1:0] stamp,
                                                   input logic [CODE_W-1:0] code,
                                                   input logic [2:0] idx);
        logic [BYTE_W-1:0] b;
        begin
            case (idx)
                3'd0:    b = frag[7:0];
                3'd1:    b = frag[15:8];
                3'd2:    b = 8'h00;
                3'd3:    b = stamp[7:0];
                3'd4:    b = stamp[15:8];
                3'd5:    b = stamp[23:16];
                3'd6:    b = stamp[31:24];
                default: b = code;
            endcase
            return b;
        end
    endfunction

    lrbf_plan_t        run_reg;
    logic [2:0]        phase_reg;
    logic [2:0]        cnt_reg;
    logic              busy_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [KIND_W-1:0] out_kind_reg;
    logic              out_last_reg;

    logic              out_free, emit, phase_end, last_slot;
    logic [2:0]        nxt_phase, start_phase;
    logic [BYTE_W-1:0] slot_byte;
    logic [KIND_W-1:0] slot_kind;

    // Current slot
    always_comb
    begin
        case (phase_reg)
            PH_HOLD:
            begin
                slot_byte = run_reg.hold_byte;
                slot_kind = KIND_PAY;
                phase_end = 1'b1;
            end
            PH_PAD:
            begin
                slot_byte = '0;
                slot_kind = KIND_PAD;
                phase_end = (cnt_reg == 3'(run_reg.pad_cnt - 3'd1));
            end
            PH_HDR1:
            begin
                slot_byte = hdr_byte(run_reg.frag1, run_reg.stamp, run_reg.code1, cnt_reg);
                slot_kind = KIND_HDR;
                phase_end = (cnt_reg == 3'd7);
            end
            PH_HDR2:
            begin
                slot_byte = hdr_byte(run_reg.frag2, run_reg.stamp, run_reg.code2, cnt_reg);
                slot_kind = KIND_HDR;
                phase_end = (cnt_reg == 3'd7);
            end
            PH_PAY:
            begin
                slot_byte = run_reg.pay_byte;
                slot_kind = KIND_PAY;
                phase_end = 1'b1;
            end
            default:
            begin
                slot_byte = '0;
                slot_kind = KIND_PAD;
                phase_end = 1'b1;
            end
        endcase
        nxt_phase   = next_phase(run_reg, phase_reg);
        start_phase = plan_in.hold_v ? PH_HOLD : next_phase(plan_in, PH_HOLD);
        last_slot   = busy_reg && phase_end && (nxt_phase == PH_DONE);
        out_free    = !out_valid_reg || out_ready;
        emit        = busy_reg && out_free;
        ready       = !busy_reg || (last_slot && out_free);
    end

    // Run sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= PH_DONE;
            cnt_reg   <= '0;
        end
        else if (load)
        begin
            busy_reg  <= 1'b1;
            phase_reg <= start_phase;
            cnt_reg   <= '0;
        end
        else if (emit)
        begin
            if (phase_end)
            begin
                phase_reg <= nxt_phase;
                cnt_reg   <= '0;
                busy_reg  <= (nxt_phase != PH_DONE);
            end
            else
            begin
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    // Plan register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            run_reg <= plan_in;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register word
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= slot_byte;
            out_kind_reg <= slot_kind;
            out_last_reg <= last_slot;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign byte_kind   = out_kind_reg;
    assign last_of_run = out_last_reg;

endmodule

// File: hw/rtl/log_record_block_framer_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Log record block framer - top level
// Frames a byte stream of log records into fixed-size blocks with headers.
// ---------------------------------------------------------------------------
// Each input word carries one payload byte (plus the record length, read at
// a record start, and the current timestamp); the block answers with the
// framed stream one output word per cycle unless out_ready or an input gap stalls
// it. A word inside a fragment yields its payload byte. A word that opens a
// fragment yields the 8-byte header, up to 7 zero bytes of block tail padding
// and the payload byte. Where a fragment would open with exactly 8 bytes left
// in the block, a header-only fragment fills the tail, a second header opens
// the next block, and the payload byte leads the next word's output. The next
// input word is taken in the cycle the current word's last byte leaves.
// No clearing pass after reset.
// ---------------------------------------------------------------------------
module log_record_block_framer_unit
    import lrbf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CODE_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [LEN_W-1:0]     record_length,
    input  logic [BYTE_W-1:0]    payload_byte,
    input  logic [STAMP_W-1:0]   timestamp_seconds,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [BYTE_W-1:0]    out_byte,
    output logic [KIND_W-1:0]    byte_kind,
    output logic                 last_of_run
);

    lrbf_plan_t plan;
    logic       accept;

    assign accept = in_valid && in_ready;

    // Framing state and per-word plan
    lrbf_plan u_plan (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .accept            (accept),
        .record_length     (record_length),
        .payload_byte      (payload_byte),
        .timestamp_seconds (timestamp_seconds),
        .plan              (plan)
    );

    // Byte serializer and output register
    lrbf_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .plan_in     (plan),
        .ready       (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .byte_kind   (byte_kind),
        .last_of_run (last_of_run)
    );

endmodule

// File: hw/rtl/lrbf_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Log record block framer - port checker
// Watches the top level's ports for output framing and handshake slips.
// ---------------------------------------------------------------------------
`include "log_record_block_framer_unit_assert.svh"

module lrbf_checker
    import lrbf_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [BYTE_W-1:0] out_byte,
    input logic [KIND_W-1:0] byte_kind,
    input logic              last_of_run
);

    // A stalled output word holds
    `LRBF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(byte_kind) && $stable(last_of_run), "output word changed while stalled")

    // Only the three defined kinds appear
    `LRBF_ASSERT_NOW(a_kind_legal, out_valid, byte_kind == KIND_PAD || byte_kind == KIND_HDR || byte_kind == KIND_PAY, "undefined byte kind")

    // Tail padding is zero and never closes a run
    `LRBF_ASSERT_NOW(a_pad_zero, out_valid && byte_kind == KIND_PAD, out_byte == '0 && !last_of_run, "bad padding word")

    // A payload word that does not close its run is never followed by padding
    `LRBF_ASSERT_NEXT(a_pay_run, out_valid && out_ready && byte_kind == KIND_PAY && !last_of_run, !(out_valid && byte_kind == KIND_PAD), "padding right after held payload")

endmodule

bind log_record_block_framer_unit lrbf_checker u_lrbf_checker (.*);

// File: bench/log_framer_check.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Log record block framer - stream checker
// Watches the config port and both channels of the framer. It predicts the
// framed byte stream for every accepted input word and compares each
// accepted output word against the oldest prediction.
// ---------------------------------------------------------------------------
module log_framer_check
    import lrbf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CODE_W-1:0]    cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [LEN_W-1:0]     record_length,
    input  logic [BYTE_W-1:0]    payload_byte,
    input  logic [STAMP_W-1:0]   timestamp_seconds,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [BYTE_W-1:0]    out_byte,
    input  logic [KIND_W-1:0]    byte_kind,
    input  logic                 last_of_run,
    output int                   errors,
    output int                   pending
);

    // Output bytes per input word are capped; the overflow is carried over
    localparam int MAX_RUN    = 16;
    localparam int HOLD_DEPTH = 4;
    localparam int PRINT_CAP  = 40;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic [KIND_W-1:0] kind;
        logic              last;
    } framed_byte_t;

    // Type byte registers
    logic [CODE_W-1:0] code_full;
    logic [CODE_W-1:0] code_first;
    logic [CODE_W-1:0] code_middle;
    logic [CODE_W-1:0] code_last;

    // Framing state
    int unsigned blk_pos;
    int unsigned rec_left;
    int unsigned frag_left;
    logic        first_frag;

    framed_byte_t held_bytes[$];
    framed_byte_t run_bytes[$];
    framed_byte_t expected_bytes[$];
    framed_byte_t oldest;
    int unsigned  out_seen;

    task automatic report_mismatch(input string what);
        // keep the log short if the design is badly off
        if (errors < PRINT_CAP)
            $display("%0t ns: output word %0d: %s", $time, out_seen, what);
        errors++;
    endtask

    function automatic void add_run_byte(input logic [BYTE_W-1:0] value,
                                         input logic [KIND_W-1:0] kind);
        framed_byte_t fb;
        fb.value = value;
        fb.kind  = kind;
        fb.last  = 1'b0;
        run_bytes.push_back(fb);
    endfunction

    // Pad the block tail if the header does not fit, then emit a header
    function automatic void open_fragment(input logic [STAMP_W-1:0] stamp);
        int unsigned       leftover;
        int unsigned       avail;
        int unsigned       frag;
        logic              done;
        logic [CODE_W-1:0] code;
        if (blk_pos > BLOCK_BYTES)
            blk_pos = BLOCK_BYTES;
        leftover = BLOCK_BYTES - blk_pos;
        if (leftover < HDR_BYTES)
        begin
            repeat (leftover) add_run_byte('0, KIND_PAD);
            blk_pos = 0;
        end
        avail = BLOCK_BYTES - blk_pos - HDR_BYTES;
        frag  = (rec_left < avail) ? rec_left : avail;
        done  = (frag == rec_left);
        if (first_frag && done)
            code = code_full;
        else if (first_frag)
            code = code_first;
        else if (done)
            code = code_last;
        else
            code = code_middle;

        add_run_byte(BYTE_W'(frag), KIND_HDR);
        add_run_byte(BYTE_W'(frag >> 8), KIND_HDR);
        add_run_byte(BYTE_W'(frag >> 16), KIND_HDR);
        add_run_byte(stamp[7:0], KIND_HDR);
        add_run_byte(stamp[15:8], KIND_HDR);
        add_run_byte(stamp[23:16], KIND_HDR);
        add_run_byte(stamp[31:24], KIND_HDR);
        add_run_byte(code, KIND_HDR);

        blk_pos    = (blk_pos + HDR_BYTES) & 32'hFFFF;
        frag_left  = frag & 32'hFFFF;
        first_frag = 1'b0;
    endfunction

    // Expected output bytes for one accepted input word
    function automatic void frame_word(input logic [LEN_W-1:0]   len,
                                       input logic [BYTE_W-1:0]  data,
                                       input logic [STAMP_W-1:0] stamp);
        int           n;
        int           k;
        framed_byte_t fb;
        run_bytes.delete();
        for (k = 0; k < held_bytes.size(); k++)
            run_bytes.push_back(held_bytes[k]);
        held_bytes.delete();

        if (rec_left == 0)
        begin
            rec_left   = len;
            first_frag = 1'b1;
            open_fragment(stamp);
        end
        while (rec_left > 0 && frag_left == 0)
            open_fragment(stamp);

        if (rec_left > 0)
        begin
            add_run_byte(data, KIND_PAY);
            blk_pos   = (blk_pos + 1) & 32'hFFFF;
            frag_left = (frag_left - 1) & 32'hFFFF;
            rec_left  = (rec_left - 1) & 32'hFFFFFF;
        end
        if (rec_left == 0)
            first_frag = 1'b1;

        // overflow beyond the cap leads the next word's output
        n = (run_bytes.size() < MAX_RUN) ? run_bytes.size() : MAX_RUN;
        for (k = n; k < run_bytes.size(); k++)
            if (held_bytes.size() < HOLD_DEPTH)
                held_bytes.push_back(run_bytes[k]);
        for (k = 0; k < n; k++)
        begin
            fb      = run_bytes[k];
            fb.last = (k == n - 1);
            expected_bytes.push_back(fb);
        end
    endfunction

    // Config snoop, prediction on input, comparison on output
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_full   = 8'd1;
            code_first  = 8'd2;
            code_middle = 8'd3;
            code_last   = 8'd4;
            blk_pos     = 0;
            rec_left    = 0;
            frag_left   = 0;
            first_frag  = 1'b1;
            held_bytes.delete();
            expected_bytes.delete();
            out_seen    = 0;
            errors      = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TYPE_FULL:   code_full   = cfg_data;
                    CFG_TYPE_FIRST:  code_first  = cfg_data;
                    CFG_TYPE_MIDDLE: code_middle = cfg_data;
                    CFG_TYPE_LAST:   code_last   = cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
                frame_word(record_length, payload_byte, timestamp_seconds);

            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                    report_mismatch($sformatf("unexpected word, byte %02h kind %0d",
                                              out_byte, byte_kind));
                else
                begin
                    oldest = expected_bytes.pop_front();
                    if (out_byte !== oldest.value)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  out_byte, oldest.value));
                    if (byte_kind !== oldest.kind)
                        report_mismatch($sformatf("byte_kind %0d, expected %0d",
                                                  byte_kind, oldest.kind));
                    if (last_of_run !== oldest.last)
                        report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                                  last_of_run, oldest.last));
                end
                out_seen++;
            end
        end
        pending = expected_bytes.size();
    end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Log record block framer - testbench top
// Drives log records one payload byte per word, with random idling on both
// channels, field extremes and several sets of type codes. A checker module
// predicts and compares the framed stream; this module gives the verdict.
// ---------------------------------------------------------------------------
module testbench;
    import lrbf_pkg::*;

    localparam int     RANDOM_WORDS   = 220;
    localparam int     SQUEEZE_AFTER  = 100;
    localparam int     SQUEEZE_CYCLES = 120;
    localparam longint LIMIT_NS       = 50_000_000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CODE_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [LEN_W-1:0]     record_length;
    logic [BYTE_W-1:0]    payload_byte;
    logic [STAMP_W-1:0]   timestamp_seconds;
    logic                 out_valid;
    logic                 out_ready;
    logic [BYTE_W-1:0]    out_byte;
    logic [KIND_W-1:0]    byte_kind;
    logic                 last_of_run;

    int                   errors;
    int                   pending;

    // no idling on either side once set
    bit                   calm = 1'b0;

    log_record_block_framer_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .record_length     (record_length),
        .payload_byte      (payload_byte),
        .timestamp_seconds (timestamp_seconds),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .out_byte          (out_byte),
        .byte_kind         (byte_kind),
        .last_of_run       (last_of_run)
    );

    log_framer_check frame_check (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .record_length       (record_length),
        .payload_byte        (payload_byte),
        .timestamp_seconds   (timestamp_seconds),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .out_byte            (out_byte),
        .byte_kind           (byte_kind),
        .last_of_run         (last_of_run),
        .errors              (errors),
        .pending             (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one word and hold it until taken, then maybe idle a short burst
    task automatic send_word(input logic [LEN_W-1:0]   len,
                             input logic [BYTE_W-1:0]  data,
                             input logic [STAMP_W-1:0] stamp);
        in_valid          <= 1'b1;
        record_length     <= len;
        payload_byte      <= data;
        timestamp_seconds <= stamp;
        do @(posedge clk); while (in_ready !== 1'b1);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Whole record; record_length only counts on the first word
    task automatic send_record(input int unsigned len);
        int unsigned k;
        send_word(LEN_W'(len), BYTE_W'($urandom), $urandom);
        for (k = 1; k < len; k++)
            send_word(LEN_W'($urandom), BYTE_W'($urandom), $urandom);
    endtask

    task automatic random_records(input int unsigned budget);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < budget)
        begin
            case ($urandom_range(0, 9))
                0:       len = 0;
                1:       len = $urandom_range(60, 250);
                default: len = $urandom_range(1, 24);
            endcase
            // stay within the word budget
            if (len > budget - sent)
                len = budget - sent;
            send_record(len);
            sent += (len == 0) ? 1 : len;
        end
    endtask

    // Stop offering and wait until every predicted byte has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_codes(input logic [CODE_W-1:0] full,
                                 input logic [CODE_W-1:0] first,
                                 input logic [CODE_W-1:0] middle,
                                 input logic [CODE_W-1:0] last);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TYPE_FULL;
        cfg_data  <= full;
        @(posedge clk);
        cfg_index <= CFG_TYPE_FIRST;
        cfg_data  <= first;
        @(posedge clk);
        cfg_index <= CFG_TYPE_MIDDLE;
        cfg_data  <= middle;
        @(posedge clk);
        cfg_index <= CFG_TYPE_LAST;
        cfg_data  <= last;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Output side: short stalls, plus one long hold to back the block up
    initial
    begin : sink
        int unsigned out_words;
        bit          squeezed;
        out_words = 0;
        squeezed  = 1'b0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                out_words++;
            if (!squeezed && out_words >= SQUEEZE_AFTER)
            begin
                squeezed = 1'b1;
                out_ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int k;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_TYPE_FULL;
        cfg_data          <= '0;
        in_valid          <= 1'b0;
        record_length     <= '0;
        payload_byte      <= '0;
        timestamp_seconds <= '0;
        rst_n             <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty records, one-byte records, field extremes
        send_word(24'd0, 8'hFF, 32'h0000_0000);
        send_word(24'd0, 8'h00, 32'hFFFF_FFFF);
        send_word(24'd1, 8'h00, 32'hFFFF_FFFF);
        send_word(24'd1, 8'hFF, 32'h8000_0001);
        send_word(24'd4, 8'h55, 32'h1234_5678);
        send_word(24'hFF_FFFF, 8'hAA, 32'h0000_0000);
        send_word(24'h00_0000, 8'h0F, 32'hFFFF_FFFF);
        send_word(24'h80_0000, 8'hF0, 32'h5A5A_A5A5);
        send_word(24'd2, 8'h80, 32'h0000_0001);
        send_word(24'h7F_FFFF, 8'h7F, 32'hFFFF_FFFE);
        wait_drained();

        // Random records under extreme type codes
        program_codes(8'h00, 8'hFF, 8'h80, 8'h7F);
        random_records(RANDOM_WORDS);
        wait_drained();

        // Last part without idling, ending inside a longest-length record
        calm = 1'b1;
        program_codes(8'd1, 8'd2, 8'd3, 8'd4);
        random_records(40);
        send_word(24'hFF_FFFF, BYTE_W'($urandom), $urandom);
        for (k = 0; k < 30; k++)
            send_word(LEN_W'($urandom), BYTE_W'($urandom), $urandom);
        wait_drained();
        repeat (16) @(posedge clk);

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/lrbf_pkg.sv
hw/rtl/lrbf_plan.sv
hw/rtl/lrbf_emit.sv
hw/rtl/log_record_block_framer_unit.sv
hw/rtl/lrbf_checker.sv
bench/log_framer_check.sv
bench/testbench.sv
